>>> rtl/pbst_pkg.sv
// pbst_pkg: shared types and codes of the paged bitmap slot table
// request kinds, result status codes, field widths and the result beat struct
// no dependencies
package pbst_pkg;

  localparam int VALUE_W     = 32;
  localparam int PAGE_IDX_W  = 3;
  localparam int SLOT_IDX_W  = 3;
  localparam int ITEM_CNT_W  = 7;
  localparam int PAGE_CNT_W  = 4;
  localparam int CAP_W       = 4;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_SEARCH  = 2'd2,
    REQ_COMPACT = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_PAGES  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_LOC   = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t               req_type;
    logic [VALUE_W-1:0]      value;
    logic [PAGE_IDX_W-1:0]   page_index;
    logic [SLOT_IDX_W-1:0]   slot_index;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [PAGE_IDX_W-1:0]   found_page;
    logic [SLOT_IDX_W-1:0]   found_slot;
    logic [ITEM_CNT_W-1:0]   item_count;
    logic [PAGE_CNT_W-1:0]   page_count;
    logic                    last;
  } res_t;

endpackage

>>> rtl/pbst_ram.sv
// pbst_ram: generic single write, single read port RAM with registered read
// read data holds when no read is issued
// no dependencies
module pbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pbst_outreg.sv
// pbst_outreg: result register between the sequencer and the output stream
// depends on pbst_pkg for the result struct
module pbst_outreg
  import pbst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res,
  output logic free,
  output logic valid,
  input  logic ready,
  output res_t data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= res;
    end
  end

endmodule

>>> rtl/pbst_seq.sv
// pbst_seq: request sequencer, occupancy bitmaps, counters and slot scan
// depends on pbst_pkg and pbst_ram
module pbst_seq
  import pbst_pkg::*;
#(
  parameter int MAX_PAGES      = 8,
  parameter int SLOTS_PER_PAGE = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             out_free,
  output logic             push,
  output res_t             res
);

  localparam int DEPTH    = MAX_PAGES * SLOTS_PER_PAGE;
  localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PIW      = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int SIW      = SLOTS_PER_PAGE > 1 ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int OCC_ROWS = 1 << PIW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_SCAN,
    S_USE,
    S_DONE
  } state_t;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) r = CAP_W'(1);
    else if (c > CAP_W'(SLOTS_PER_PAGE)) r = CAP_W'(SLOTS_PER_PAGE);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [PAGE_CNT_W-1:0] p,
                                            input logic [SLOT_IDX_W-1:0] s);
    return AW'(32'(p) * SLOTS_PER_PAGE + 32'(s));
  endfunction

  state_t                     state, state_next;
  req_t                       cur;
  logic [CAP_W-1:0]           cap;
  logic [SLOTS_PER_PAGE-1:0]  occ [OCC_ROWS];
  logic [PAGE_CNT_W-1:0]      pages, pages_next;
  logic [ITEM_CNT_W-1:0]      items, items_next;
  logic [PAGE_CNT_W-1:0]      rp, wp;
  logic [SLOT_IDX_W-1:0]      rs, ws;
  logic                       have, have_next;
  logic [PAGE_IDX_W-1:0]      hp;
  logic [SLOT_IDX_W-1:0]      hs;

  logic [SLOTS_PER_PAGE-1:0]  cap_mask, occ_rp, free_vec, occ_pg;
  logic [SLOT_IDX_W-1:0]      free_slot;
  logic                       scan_end, rs_last, ws_last, scan_occ, rem_bit, match;
  logic                       adv_r, adv_w, adv_p, set_en, clr_en, take_match;
  logic [PAGE_CNT_W-1:0]      set_p, clr_p;
  logic [SLOT_IDX_W-1:0]      set_s, clr_s;

  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [VALUE_W-1:0]         wr_data, rd_data;

  pbst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state == S_IDLE) && !cfg_we;

  always_comb begin
    for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
      cap_mask[i] = (CAP_W'(i) < cap);
    end
    occ_rp    = occ[rp[PIW-1:0]];
    free_vec  = ~occ_rp & cap_mask;
    free_slot = '0;
    for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--) begin
      if (free_vec[i]) free_slot = SLOT_IDX_W'(i);
    end
    scan_end = (rp >= pages);
    rs_last  = ((CAP_W'(rs) + CAP_W'(1)) >= cap);
    ws_last  = ((CAP_W'(ws) + CAP_W'(1)) >= cap);
    scan_occ = occ_rp[rs[SIW-1:0]];
    occ_pg   = occ[cur.page_index[PIW-1:0]];
    rem_bit  = (PAGE_CNT_W'(cur.page_index) < pages) &&
               (CAP_W'(cur.slot_index) < cap) ? occ_pg[cur.slot_index[SIW-1:0]] : 1'b0;
    match    = (rd_data == cur.value);
  end

  always_comb begin
    state_next = state;
    pages_next = pages;
    items_next = items;
    have_next  = have;
    take_match = 1'b0;
    push       = 1'b0;
    res        = '0;
    res.status = ST_OK;
    rd_en      = 1'b0;
    rd_addr    = addr_of(rp, rs);
    wr_en      = 1'b0;
    wr_addr    = addr_of(wp, ws);
    wr_data    = rd_data;
    adv_r      = 1'b0;
    adv_w      = 1'b0;
    adv_p      = 1'b0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    set_p      = wp;
    set_s      = ws;
    clr_p      = rp;
    clr_s      = rs;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          have_next = 1'b0;
          case (req.req_type)
            REQ_INSERT: begin
              state_next = S_INS;
              if (pages == '0) pages_next = PAGE_CNT_W'(1);
            end
            REQ_REMOVE: state_next = S_REM;
            default:    state_next = (pages == '0) ? S_DONE : S_SCAN;
          endcase
        end
      end
      S_INS: begin
        res.last = 1'b1;
        wr_data  = cur.value;
        if (scan_end) begin
          if (out_free) begin
            push       = 1'b1;
            state_next = S_IDLE;
            if (pages < PAGE_CNT_W'(MAX_PAGES)) begin
              res.found_page = PAGE_IDX_W'(pages);
              wr_en      = 1'b1;
              wr_addr    = addr_of(pages, '0);
              set_en     = 1'b1;
              set_p      = pages;
              set_s      = '0;
              pages_next = pages + PAGE_CNT_W'(1);
              items_next = items + ITEM_CNT_W'(1);
            end else begin
              res.status = ST_FULL;
            end
          end
        end else if (free_vec != '0) begin
          if (out_free) begin
            push           = 1'b1;
            state_next     = S_IDLE;
            res.found_page = PAGE_IDX_W'(rp);
            res.found_slot = free_slot;
            wr_en          = 1'b1;
            wr_addr        = addr_of(rp, free_slot);
            set_en         = 1'b1;
            set_p          = rp;
            set_s          = free_slot;
            items_next     = items + ITEM_CNT_W'(1);
          end
        end else begin
          adv_p = 1'b1;
        end
      end
      S_REM: begin
        res.last = 1'b1;
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (pages == '0) begin
            res.status = ST_NO_PAGES;
          end else if (!rem_bit) begin
            res.status = ST_BAD_LOC;
          end else begin
            res.found_page = cur.page_index;
            res.found_slot = cur.slot_index;
            clr_en         = 1'b1;
            clr_p          = PAGE_CNT_W'(cur.page_index);
            clr_s          = cur.slot_index;
            items_next     = items - ITEM_CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end else if (scan_occ) begin
          rd_en      = 1'b1;
          state_next = S_USE;
        end else begin
          adv_r = 1'b1;
        end
      end
      S_USE: begin
        if (cur.req_type == REQ_COMPACT) begin
          wr_en      = 1'b1;
          clr_en     = 1'b1;
          set_en     = 1'b1;
          adv_w      = 1'b1;
          adv_r      = 1'b1;
          state_next = S_SCAN;
        end else if (!(match && have && !out_free)) begin
          if (match && have) begin
            push           = 1'b1;
            res.found_page = hp;
            res.found_slot = hs;
          end
          take_match = match;
          have_next  = have | match;
          adv_r      = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        res.last = 1'b1;
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (pages == '0) begin
            res.status = ST_NO_PAGES;
          end else if (cur.req_type == REQ_COMPACT) begin
            pages_next = (ws == '0) ? wp : wp + PAGE_CNT_W'(1);
          end else if (have) begin
            res.found_page = hp;
            res.found_slot = hs;
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    res.item_count = items_next;
    res.page_count = pages_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= eff_cap(CAP_W'(8));
      pages <= PAGE_CNT_W'(1);
      items <= '0;
      have  <= 1'b0;
      rp    <= '0;
      rs    <= '0;
      wp    <= '0;
      ws    <= '0;
      for (int i = 0; i < OCC_ROWS; i++) occ[i] <= '0;
    end else if (cfg_we) begin
      cap   <= eff_cap(cfg_data);
      pages <= PAGE_CNT_W'(1);
      items <= '0;
      for (int i = 0; i < OCC_ROWS; i++) occ[i] <= '0;
    end else begin
      state <= state_next;
      pages <= pages_next;
      items <= items_next;
      have  <= have_next;
      if (state == S_IDLE && req_valid) begin
        cur  <= req;
        rp   <= '0;
        rs   <= '0;
        wp   <= '0;
        ws   <= '0;
      end
      if (take_match) begin
        hp <= PAGE_IDX_W'(rp);
        hs <= rs;
      end
      if (adv_p) rp <= rp + PAGE_CNT_W'(1);
      if (adv_r) begin
        if (rs_last) begin
          rs <= '0;
          rp <= rp + PAGE_CNT_W'(1);
        end else begin
          rs <= rs + SLOT_IDX_W'(1);
        end
      end
      if (adv_w) begin
        if (ws_last) begin
          ws <= '0;
          wp <= wp + PAGE_CNT_W'(1);
        end else begin
          ws <= ws + SLOT_IDX_W'(1);
        end
      end
      if (clr_en && !(set_en && clr_p == set_p && clr_s == set_s)) begin
        occ[clr_p[PIW-1:0]][clr_s[SIW-1:0]] <= 1'b0;
      end
      if (set_en) occ[set_p[PIW-1:0]][set_s[SIW-1:0]] <= 1'b1;
    end
  end

endmodule

>>> rtl/paged_bitmap_slot_table.sv
// paged_bitmap_slot_table: top level, stream ports, config port and field packing
// depends on pbst_pkg, pbst_seq, pbst_outreg
//
// channel   direction  signals                              content
// s_*       in         s_tvalid s_tready s_tdata s_tuser    one request per beat
// m_*       out        m_tvalid m_tready m_tdata m_tuser    result beats, m_tlast on final
// cfg_*     in         cfg_valid cfg_ready cfg_data         page capacity write
//
// insert checks one page bitmap per cycle, then holds until the output register is free
// remove is decided in the single S_REM state; search and compact scan every slot of the pages
// in use, reading the slot RAM only for occupied slots, bound by the single slot RAM read port
// the block is busy from request beat to final result; one result waits in the output register
// reset clears bitmaps and item count and sets page count to one; the slot RAM is not cleared
// a stalled output holds the scan until the pending result beat is taken
module paged_bitmap_slot_table
  import pbst_pkg::*;
#(
  parameter int MAX_PAGES      = 8,
  parameter int SLOTS_PER_PAGE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // value[31:0], page_index[34:32], slot_index[37:35], zero
  input  logic [1:0]  s_tuser,    // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // found_page[2:0], found_slot[5:3], item_count[12:6],
                                  // page_count[16:13], zero
  output logic [2:0]  m_tuser,    // status[2:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  req_t req;
  res_t res, out_res;
  logic push, out_free;

  assign req.req_type   = req_type_t'(s_tuser);
  assign req.value      = s_tdata[31:0];
  assign req.page_index = s_tdata[34:32];
  assign req.slot_index = s_tdata[37:35];

  assign cfg_ready = 1'b1;

  pbst_seq #(
    .MAX_PAGES      (MAX_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .push      (push),
    .res       (res)
  );

  pbst_outreg u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .res   (res),
    .free  (out_free),
    .valid (m_tvalid),
    .ready (m_tready),
    .data  (out_res)
  );

  assign m_tdata = {7'd0, out_res.page_count, out_res.item_count,
                    out_res.found_slot, out_res.found_page};
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.last;

endmodule
